/* rtl/core/periodic_timer_bank_macros.svh */
// ----------------------------------------------------------------------------
// periodic_timer_bank_macros.svh - assertion helpers
// Concurrent assertion wrappers clocked on clk; one gated by reset, one not.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_MACROS_SVH
`define PERIODIC_TIMER_BANK_MACROS_SVH

// Check a property outside reset
`define PTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define PTB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/ptb_pkg.sv */
// ----------------------------------------------------------------------------
// ptb_pkg - shared definitions for the periodic timer bank
// Sizes, action and state codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

  localparam int TIMERS      = 8;
  localparam int IDX_W       = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int ID_W        = 3;
  localparam int TIME_W      = 32;
  localparam int ACTION_W    = 3;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE = 3'd0,
    ACT_START  = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_RESET  = 3'd3,
    ACT_KILL   = 3'd4,
    ACT_STATUS = 3'd5,
    ACT_TICK   = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    RS_NEVER   = 2'd0,
    RS_RUNNING = 2'd1,
    RS_STOPPED = 2'd2
  } run_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FLUSH
  } ctrl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture input transfer, clear scan
    logic exec;      // perform non-tick action and post its result
    logic scan_adv;  // move scan to the next timer
    logic take_due;  // advance deadline of scanned timer, post held expiry
    logic flush;     // post final tick result
  } ptb_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic slot_free;
    logic due;
    logic scan_last;
    logic pend_valid;
    logic cap_full;
  } ptb_stat_t;

endpackage

`default_nettype wire

/* rtl/core/ptb_ctrl.sv */
// ----------------------------------------------------------------------------
// ptb_ctrl - sequencer for the periodic timer bank
// Accepts one item, runs a command or a timer scan, and posts results.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ctrl
  import ptb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire ptb_stat_t stat,
  output ptb_cmd_t       cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // refuse transfers while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_tick) begin
          state_nxt = ST_SCAN;
        end else if (stat.slot_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat.due && !stat.cap_full) begin
          // hold until the previous expiry can be posted
          if (!stat.pend_valid || stat.slot_free) begin
            cmd.take_due = 1'b1;
            if (stat.scan_last) begin
              state_nxt = ST_FLUSH;
            end else begin
              cmd.scan_adv = 1'b1;
            end
          end
        end else if (stat.scan_last) begin
          state_nxt = ST_FLUSH;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (stat.slot_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/ptb_datapath.sv */
// ----------------------------------------------------------------------------
// ptb_datapath - timer storage, scan unit and result register
// Holds per-timer state, executes commands and scans deadlines one per cycle unless a held expiry stalls the scan.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_timer_bank_macros.svh"

module ptb_datapath
  import ptb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [ACTION_W-1:0]    in_tuser,
  input  wire ptb_cmd_t               cmd,
  output ptb_stat_t                   stat,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser,
  output logic                        out_tlast
);

  // Captured item
  action_t             act_r;
  logic [ID_W-1:0]     tid_r;
  logic [TIME_W-1:0]   per_r;
  logic [TIME_W-1:0]   now_r;

  // Timer storage
  logic                alloc_r  [TIMERS];
  run_state_t          tstate_r [TIMERS];
  logic [TIME_W-1:0]   period_r [TIMERS];
  logic [TIME_W-1:0]   dl_r     [TIMERS];

  // Scan state
  logic [IDX_W-1:0]    scan_idx_r;
  logic [CNT_W-1:0]    n_r;
  logic                pend_valid_r;
  logic [ID_W-1:0]     pend_id_r;

  // Result register
  logic                out_valid_r;
  logic                res_code_r;
  logic [ID_W-1:0]     res_id_r;
  run_state_t          res_rs_r;
  logic                res_ev_r;
  logic                res_last_r;

  logic [IDX_W-1:0]    tid_idx;
  logic                id_ok;
  logic [TIME_W-1:0]   scan_period;
  logic [TIME_W-1:0]   scan_dl;
  logic                due;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic                exec_code;
  logic [ID_W-1:0]     exec_id;
  run_state_t          exec_rs;
  logic                emit;
  logic                slot_free;

  assign tid_idx = IDX_W'(tid_r);
  assign id_ok   = (32'(tid_r) < TIMERS) && alloc_r[tid_idx];

  // Deadline check for the scanned timer
  assign scan_period = period_r[scan_idx_r];
  assign scan_dl     = dl_r[scan_idx_r];
  assign due         = (scan_period != '0) && (now_r >= scan_dl);

  // Lowest free timer
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!alloc_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Result of a non-tick action
  always_comb begin
    exec_code = ~id_ok;
    exec_id   = '0;
    exec_rs   = RS_NEVER;
    unique case (act_r) inside
      ACT_CREATE: begin
        exec_code = ~free_found;
        exec_id   = free_found ? ID_W'(free_idx) : '0;
      end
      ACT_STATUS: begin
        exec_rs = id_ok ? tstate_r[tid_idx] : RS_NEVER;
      end
      ACT_START, ACT_STOP, ACT_RESET, ACT_KILL: begin
        exec_code = ~id_ok;
      end
      default: begin
        exec_code = 1'b1;
      end
    endcase
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(in_tuser);
      tid_r <= in_tdata[ID_W-1:0];
      per_r <= in_tdata[ID_W +: TIME_W];
      now_r <= in_tdata[ID_W+TIME_W +: TIME_W];
    end
  end

  // Allocation, run state and period
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TIMERS; i++) begin
        alloc_r[i]  <= 1'b0;
        tstate_r[i] <= RS_NEVER;
        period_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      unique case (act_r) inside
        ACT_CREATE: begin
          if (free_found) begin
            alloc_r[free_idx] <= 1'b1;
          end
        end
        ACT_START, ACT_RESET: begin
          if (id_ok) begin
            period_r[tid_idx] <= per_r;
            tstate_r[tid_idx] <= RS_RUNNING;
          end
        end
        ACT_STOP: begin
          if (id_ok && tstate_r[tid_idx] == RS_RUNNING) begin
            period_r[tid_idx] <= '0;
            tstate_r[tid_idx] <= RS_STOPPED;
          end
        end
        ACT_KILL: begin
          if (id_ok) begin
            alloc_r[tid_idx] <= 1'b0;
            if (tstate_r[tid_idx] == RS_RUNNING) begin
              period_r[tid_idx] <= '0;
              tstate_r[tid_idx] <= RS_STOPPED;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Deadlines: set on start or reset, advance on expiry
  always_ff @(posedge clk) begin
    if (cmd.exec && id_ok && (act_r == ACT_START || act_r == ACT_RESET)) begin
      dl_r[tid_idx] <= now_r + per_r;
    end else if (cmd.take_due) begin
      dl_r[scan_idx_r] <= scan_dl + scan_period;
    end
  end

  // Scan index, expiry count and held expiry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      scan_idx_r   <= '0;
      n_r          <= '0;
    end else if (cmd.load) begin
      pend_valid_r <= 1'b0;
      scan_idx_r   <= '0;
      n_r          <= '0;
    end else begin
      if (cmd.take_due) begin
        pend_valid_r <= 1'b1;
        n_r          <= n_r + 1'b1;
      end
      if (cmd.scan_adv) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_due) begin
      pend_id_r <= ID_W'(scan_idx_r);
    end
  end

  // Result register
  assign emit      = cmd.exec || cmd.flush || (cmd.take_due && pend_valid_r);
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_code_r <= exec_code;
      res_id_r   <= exec_id;
      res_rs_r   <= exec_rs;
      res_ev_r   <= 1'b0;
      res_last_r <= 1'b1;
    end else if (cmd.take_due && pend_valid_r) begin
      res_code_r <= 1'b0;
      res_id_r   <= pend_id_r;
      res_rs_r   <= RS_NEVER;
      res_ev_r   <= 1'b1;
      res_last_r <= 1'b0;
    end else if (cmd.flush) begin
      res_code_r <= 1'b0;
      res_id_r   <= pend_valid_r ? pend_id_r : '0;
      res_rs_r   <= RS_NEVER;
      res_ev_r   <= pend_valid_r;
      res_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ID_W - 3){1'b0}}, res_rs_r, res_id_r, res_code_r};
  assign out_tuser  = res_ev_r;
  assign out_tlast  = res_last_r;

  // Status to the controller
  always_comb begin
    stat            = '0;
    stat.is_tick    = (act_r == ACT_TICK);
    stat.slot_free  = slot_free;
    stat.due        = due;
    stat.scan_last  = (scan_idx_r == IDX_W'(TIMERS - 1));
    stat.pend_valid = pend_valid_r;
    stat.cap_full   = (n_r == CNT_W'(MAX_RESULTS));
  end

  // Checks
  `PTB_ASSERT(a_no_overwrite, !(emit && out_valid_r && !out_tready), "result overwritten")
  `PTB_ASSERT(a_cap_bound, n_r <= CNT_W'(MAX_RESULTS), "expiry count past limit")
  `PTB_ASSERT(a_take_sets_pend, cmd.take_due |=> pend_valid_r, "expiry not held")
  `PTB_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

`default_nettype wire

/* rtl/core/periodic_timer_bank.sv */
// ----------------------------------------------------------------------------
// periodic_timer_bank - bank of periodic millisecond timers
// Create, start, stop, reset, kill and query timers; a tick item reports
// every timer whose deadline has passed, one expiry per timer per tick.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in_*      slave      in_tvalid/in_tready     tdata: id/period/now, tuser: action
//  out_*     master     out_tvalid/out_tready   tdata: code/id/state, tuser, tlast
//
//  A non-tick item is accepted, then executed once the result register is free.
//  A tick is accepted and decoded, then runs the deadline scan timer by
//  timer and then posts the final result.
//  Reset (rst_n low, synchronous) frees every timer and clears the result.
//  A stalled output holds the scan at the next expiry until the held
//  result register drains; a new item is taken while the last result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_bank
  import ptb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [2:0] timer_id, [34:3] period_ms, [66:35] now_ms, [71:67] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [2:0] action
  input  wire logic [ACTION_W-1:0]    in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [0] result_code, [3:1] id_out, [5:4] run_state, [7:6] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // [0] event_valid
  output logic                        out_tuser,
  output logic                        out_tlast
);

  ptb_cmd_t  cmd;
  ptb_stat_t stat;

  // Sequencer
  ptb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage, scan and result register
  ptb_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

/* dv/ptb_checker.sv */
// ----------------------------------------------------------------------------
// ptb_checker - result checker for the periodic timer bank
// Watches the input and result streams, keeps its own copy of the timer
// store, predicts the results of every input transfer and compares each
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_checker
  import ptb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  // [2:0] timer_id, [34:3] period_ms, [66:35] now_ms, [71:67] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [2:0] action
  input  wire logic [ACTION_W-1:0]    in_tuser,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  // [0] result_code, [3:1] id_out, [5:4] run_state, [7:6] zero
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] event_valid
  input  wire logic                   out_tuser,
  input  wire logic                   out_tlast,
  output int unsigned                 mismatch_count,
  output int unsigned                 outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic RC_OK   = 1'b0;
  localparam logic RC_FAIL = 1'b1;

  typedef struct packed {
    logic             result_code;
    logic [ID_W-1:0]  id_out;
    run_state_t       run_state;
    logic             event_valid;
    logic             last_flag;
  } tmr_result_t;

  // Shadow of the timer store
  logic              timer_allocated [TIMERS];
  run_state_t        timer_run       [TIMERS];
  logic [TIME_W-1:0] timer_period    [TIMERS];
  logic [TIME_W-1:0] timer_deadline  [TIMERS];

  tmr_result_t pending_results [$];
  tmr_result_t head_result;
  tmr_result_t seen_result;

  function automatic void queue_result(logic code, logic [ID_W-1:0] id, run_state_t rs,
                                       logic ev, logic lst);
    tmr_result_t r;
    r.result_code = code;
    r.id_out      = id;
    r.run_state   = rs;
    r.event_valid = ev;
    r.last_flag   = lst;
    pending_results.push_back(r);
  endfunction

  // Stop a running timer; anything else is left alone
  function automatic void halt_timer(int t);
    if (timer_run[t] == RS_RUNNING) begin
      timer_period[t] = '0;
      timer_run[t]    = RS_STOPPED;
    end
  endfunction

  function automatic void launch_timer(int t, logic [TIME_W-1:0] per,
                                       logic [TIME_W-1:0] stamp);
    timer_period[t]   = per;
    timer_deadline[t] = stamp + per;
    timer_run[t]      = RS_RUNNING;
  endfunction

  // Update the shadow store for one input transfer and queue its results
  function automatic void apply_action(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                                       logic [TIME_W-1:0] per, logic [TIME_W-1:0] stamp);
    logic ok;
    logic found;
    int   slot;
    logic hit [TIMERS];
    int   final_hit;
    ok        = timer_allocated[id];
    found     = 1'b0;
    slot      = 0;
    final_hit = -1;
    case (act)
      ACT_CREATE: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (!found && !timer_allocated[i]) begin
            found = 1'b1;
            slot  = i;
          end
        end
        if (found) begin
          timer_allocated[slot] = 1'b1;
          queue_result(RC_OK, ID_W'(slot), RS_NEVER, 1'b0, 1'b1);
        end else begin
          queue_result(RC_FAIL, '0, RS_NEVER, 1'b0, 1'b1);
        end
      end
      ACT_START: begin
        if (ok) launch_timer(id, per, stamp);
        queue_result(ok ? RC_OK : RC_FAIL, '0, RS_NEVER, 1'b0, 1'b1);
      end
      ACT_STOP: begin
        if (ok) halt_timer(id);
        queue_result(ok ? RC_OK : RC_FAIL, '0, RS_NEVER, 1'b0, 1'b1);
      end
      ACT_RESET: begin
        if (ok) begin
          halt_timer(id);
          launch_timer(id, per, stamp);
        end
        queue_result(ok ? RC_OK : RC_FAIL, '0, RS_NEVER, 1'b0, 1'b1);
      end
      ACT_KILL: begin
        if (ok) begin
          halt_timer(id);
          timer_allocated[id] = 1'b0;
        end
        queue_result(ok ? RC_OK : RC_FAIL, '0, RS_NEVER, 1'b0, 1'b1);
      end
      ACT_STATUS: begin
        queue_result(ok ? RC_OK : RC_FAIL, '0, ok ? timer_run[id] : RS_NEVER, 1'b0, 1'b1);
      end
      ACT_TICK: begin
        // Mark due timers and advance their deadlines, at most one expiry each
        for (int i = 0; i < TIMERS; i++) begin
          hit[i] = (timer_period[i] != '0) && (stamp >= timer_deadline[i]);
          if (hit[i]) begin
            timer_deadline[i] = timer_deadline[i] + timer_period[i];
            final_hit = i;
          end
        end
        if (final_hit < 0) begin
          queue_result(RC_OK, '0, RS_NEVER, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < TIMERS; i++) begin
            if (hit[i]) queue_result(RC_OK, ID_W'(i), RS_NEVER, 1'b1, i == final_hit);
          end
        end
      end
      default: begin
        queue_result(RC_FAIL, '0, RS_NEVER, 1'b0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TIMERS; i++) begin
        timer_allocated[i] = 1'b0;
        timer_run[i]       = RS_NEVER;
        timer_period[i]    = '0;
        timer_deadline[i]  = '0;
      end
      pending_results.delete();
      mismatch_count = 0;
      outstanding    = 0;
    end else begin
      // Check the result transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        seen_result.result_code = out_tdata[0];
        seen_result.id_out      = out_tdata[3:1];
        seen_result.run_state   = run_state_t'(out_tdata[5:4]);
        seen_result.event_valid = out_tuser;
        seen_result.last_flag   = out_tlast;
        if (pending_results.size() == 0) begin
          $display("%0t ptb_checker: unexpected result code=%0b id=%0d state=%0d ev=%0b last=%0b",
                   $time, seen_result.result_code, seen_result.id_out,
                   seen_result.run_state, seen_result.event_valid, seen_result.last_flag);
          mismatch_count++;
        end else begin
          head_result = pending_results.pop_front();
          if (seen_result.result_code !== head_result.result_code ||
              seen_result.id_out      !== head_result.id_out      ||
              seen_result.run_state   !== head_result.run_state   ||
              seen_result.event_valid !== head_result.event_valid ||
              seen_result.last_flag   !== head_result.last_flag) begin
            $display("%0t ptb_checker: mismatch expected code=%0b id=%0d state=%0d ev=%0b last=%0b, actual code=%0b id=%0d state=%0d ev=%0b last=%0b",
                     $time, head_result.result_code, head_result.id_out,
                     head_result.run_state, head_result.event_valid, head_result.last_flag,
                     seen_result.result_code, seen_result.id_out,
                     seen_result.run_state, seen_result.event_valid, seen_result.last_flag);
            mismatch_count++;
          end
        end
      end
      // Predict the results of the input transfer
      if (in_tvalid && in_tready) begin
        apply_action(in_tuser, in_tdata[2:0], in_tdata[34:3], in_tdata[66:35]);
      end
      outstanding = pending_results.size();
    end
  end

endmodule

`default_nettype wire

/* dv/tb_periodic_timer_bank.sv */
// ----------------------------------------------------------------------------
// tb_periodic_timer_bank - testbench top for the periodic timer bank
// Drives a directed sequence covering failures on free timers, a full bank,
// wrapping deadlines and unused action codes, then random timer traffic
// with random gaps and result stalls; ptb_checker does the comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_periodic_timer_bank;
  import ptb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 192;
  localparam int DRAIN_CYCLES = TIMERS + 12;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [ACTION_W-1:0]    in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  int unsigned            mismatch_count;
  int unsigned            outstanding;
  logic                   no_idle = 1'b0;

  always #5 clk = ~clk;

  periodic_timer_bank i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  ptb_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Stall the result side at random
  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 28);
  end

  // Present one item at a falling edge and hold it until the transfer
  task automatic send_item(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                           logic [TIME_W-1:0] per, logic [TIME_W-1:0] stamp);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {5'd0, stamp, per, id};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop valid for a random gap now and then
  task automatic maybe_idle();
    int n;
    if (!no_idle && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      n = $urandom_range(3, 1);
      repeat (n) @(negedge clk);
    end
  endtask

  // Hold the sender until every predicted result has come out
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int                  pick;
    logic [ACTION_W-1:0] act;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   per;
    logic [TIME_W-1:0]   stamp;
    logic [TIME_W-1:0]   clock_ms;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every action on a free timer fails; an empty bank ticks quietly
    send_item(ACT_STATUS, 3'd0, 32'd0, 32'd0);
    send_item(ACT_START, 3'd7, 32'd5, 32'd0);
    send_item(ACT_STOP, 3'd3, 32'd0, 32'd0);
    send_item(ACT_RESET, 3'd5, 32'd9, 32'd1);
    send_item(ACT_KILL, 3'd6, 32'd0, 32'd0);
    send_item(ACT_TICK, 3'd0, 32'd0, 32'd0);
    // Fill the bank, then one create too many
    repeat (TIMERS + 1) send_item(ACT_CREATE, 3'd0, 32'd0, 32'd0);
    // Wrapping deadlines and a zero period
    send_item(ACT_START, 3'd0, 32'd1, 32'hFFFF_FFFF);
    send_item(ACT_START, 3'd1, 32'hFFFF_FFFF, 32'd0);
    send_item(ACT_START, 3'd2, 32'd0, 32'd0);
    send_item(ACT_STATUS, 3'd2, 32'd0, 32'd0);
    send_item(ACT_TICK, 3'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(ACT_STOP, 3'd1, 32'd0, 32'd0);
    send_item(ACT_STATUS, 3'd1, 32'd0, 32'd0);
    send_item(ACT_RESET, 3'd3, 32'd5, 32'd10);
    send_item(ACT_KILL, 3'd0, 32'd0, 32'd0);
    send_item(ACT_STATUS, 3'd0, 32'd0, 32'd0);
    send_item(ACT_UNUSED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // A recycled timer keeps its stopped state
    send_item(ACT_CREATE, 3'd0, 32'd0, 32'd0);
    send_item(ACT_STATUS, 3'd0, 32'd0, 32'd0);
    wait_drain();

    // Random traffic: mostly well-formed timing with some noise
    clock_ms = 32'd20;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      no_idle = (k >= 60 && k < 120);
      if (k == 150) begin
        // Pause until drained, then run the clock across the wrap point
        wait_drain();
        clock_ms = 32'hFFFF_FF00;
      end
      pick  = $urandom_range(99);
      id    = ID_W'($urandom_range(TIMERS - 1));
      per   = '0;
      stamp = clock_ms;
      if (pick < 34) begin
        act = ACT_TICK;
        if (pick < 3) begin
          stamp = $urandom();
        end else begin
          clock_ms = clock_ms + $urandom_range(12);
          stamp    = clock_ms;
        end
      end else if (pick < 54) begin
        act = (pick < 46) ? ACT_START : ACT_RESET;
        case ($urandom_range(9))
          0:       per = '0;
          1:       per = $urandom();
          default: per = $urandom_range(24, 1);
        endcase
        if ($urandom_range(9) == 0) stamp = $urandom();
      end else if (pick < 66) begin
        act = ACT_CREATE;
      end else if (pick < 74) begin
        act = ACT_STOP;
      end else if (pick < 82) begin
        act = ACT_KILL;
      end else if (pick < 97) begin
        act = ACT_STATUS;
      end else begin
        act   = ACT_UNUSED;
        per   = $urandom();
        stamp = $urandom();
      end
      maybe_idle();
      send_item(act, id, per, stamp);
    end
    no_idle = 1'b0;
    wait_drain();

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
